[design/srtf_process_scheduler_macros.svh]
// Assertion macros used by the scheduler top level.
`ifndef SRTF_PROCESS_SCHEDULER_MACROS_SVH
`define SRTF_PROCESS_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SRTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srtf assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SRTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srtf assertion failed");

`endif

[design/srtf_pkg.sv]
// Types and constants of the SRTF process scheduler.
package srtf_pkg;

    localparam int SLOTS = 16;
    localparam int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_FULL   = 2'd1,
        ST_SERVED = 2'd2,
        ST_IDLE   = 2'd3
    } t_status;

    typedef enum logic {
        OP_ARRIVE = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    typedef struct packed {
        t_op         operation;
        logic [7:0]  proc_id;
        logic [15:0] burst;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [7:0]  served_id;
        logic        finished;
        logic [31:0] completion_time;
        logic [31:0] turnaround;
        logic [31:0] waiting;
    } t_out_word;

    // One process table entry as stored in the slot RAM.
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] rem;
        logic [15:0] burst;
        logic [31:0] arr;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[design/srtf_if.sv]
// Valid/ready channel interfaces for scheduler input and result words.
interface srtf_in_if;
    logic               valid;
    logic               ready;
    srtf_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srtf_out_if;
    logic                valid;
    logic                ready;
    srtf_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/srtf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/srtf_cmp.sv]
// Priority compare: candidate beats best on less remaining time, then earlier arrival.
module srtf_cmp (
    input  srtf_pkg::t_entry i_cand,
    input  srtf_pkg::t_entry i_best,
    output logic             o_lt
);

    logic rem_lt;
    logic rem_eq;
    logic arr_lt;

    assign rem_lt = i_cand.rem < i_best.rem;
    assign rem_eq = i_cand.rem == i_best.rem;
    assign arr_lt = i_cand.arr < i_best.arr;

    // Strict compare keeps the lower slot on a full tie.
    assign o_lt = rem_lt || (rem_eq && arr_lt);

endmodule

[design/srtf_process_scheduler.sv]
// Top level of the shortest-remaining-time-first process scheduler.
//
//  channel   dir  modport  word
//  i_in      in   sink     operation, proc_id, burst
//  o_out     out  source   status, served_id, finished, completion_time,
//                          turnaround, waiting
//
// Arrival: one slot valid bit is checked per cycle until a free slot is found.
// Tick: one slot RAM read and one compare per cycle over all slots, then the
// update and, when the process finishes, turnaround and then waiting.
// Reset (i_rst_n low, synchronous) clears all slot valid bits and the time.
// A word is taken only when the sequencer is idle; a result waiting on o_out
// holds the sequencer in its last step until the output register frees up.
`include "srtf_process_scheduler_macros.svh"

module srtf_process_scheduler (
    input logic        i_clk,
    input logic        i_rst_n,
    srtf_in_if.sink    i_in,
    srtf_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_LAST,
        S_UPD,
        S_TAT,
        S_WT,
        S_DONE
    } t_state;

    localparam logic [srtf_pkg::IDXW-1:0] LAST_IDX = srtf_pkg::IDXW'(srtf_pkg::SLOTS - 1);

    t_state                        r_state;
    logic [srtf_pkg::SLOTS-1:0]    r_valid;
    logic [31:0]                   r_time;
    logic [srtf_pkg::IDXW-1:0]     r_cnt;
    srtf_pkg::t_in_word            r_item;
    logic                          r_pend_act;
    logic                          r_pend_v;
    logic [srtf_pkg::IDXW-1:0]     r_pend_idx;
    logic                          r_found;
    logic [srtf_pkg::IDXW-1:0]     r_best_idx;
    srtf_pkg::t_entry              r_best;
    logic [31:0]                   r_ct;
    logic [31:0]                   r_tat;
    srtf_pkg::t_out_word           r_res;
    logic                          r_out_valid;
    srtf_pkg::t_out_word           r_out;

    logic                          in_fire;
    logic                          out_free;
    logic                          ram_we;
    logic [srtf_pkg::IDXW-1:0]     ram_waddr;
    srtf_pkg::t_entry              ram_wdata;
    logic [srtf_pkg::ENTRY_W-1:0]  ram_rdata;
    srtf_pkg::t_entry              rd_entry;
    logic                          cmp_lt;
    logic                          take;
    logic [31:0]                   sub_a;
    logic [31:0]                   sub_b;
    logic [31:0]                   sub_y;

    function automatic srtf_pkg::t_out_word make_res(
        srtf_pkg::t_status st,
        logic [7:0]        id,
        logic              fin,
        logic [31:0]       ct,
        logic [31:0]       tat,
        logic [31:0]       wt
    );
        srtf_pkg::t_out_word w;
        w.status          = st;
        w.served_id       = id;
        w.finished        = fin;
        w.completion_time = ct;
        w.turnaround      = tat;
        w.waiting         = wt;
        return w;
    endfunction

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    srtf_ram #(
        .WIDTH (srtf_pkg::ENTRY_W),
        .DEPTH (srtf_pkg::SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = srtf_pkg::t_entry'(ram_rdata);

    srtf_cmp u_cmp (
        .i_cand (rd_entry),
        .i_best (r_best),
        .o_lt   (cmp_lt)
    );

    assign take = r_pend_act && r_pend_v && (!r_found || cmp_lt);

    // Shared subtractor: turnaround first, then waiting.
    assign sub_a = (r_state == S_WT) ? r_tat : r_ct;
    assign sub_b = (r_state == S_WT) ? {16'd0, r_best.burst} : r_best.arr;
    assign sub_y = sub_a - sub_b;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = r_best;
        unique case (r_state)
            S_FIND: begin
                ram_we          = !r_valid[r_cnt];
                ram_wdata.id    = r_item.proc_id;
                ram_wdata.rem   = r_item.burst;
                ram_wdata.burst = r_item.burst;
                ram_wdata.arr   = r_time;
            end
            S_UPD: begin
                ram_we        = r_found && (r_best.rem > 16'd1);
                ram_waddr     = r_best_idx;
                ram_wdata.rem = r_best.rem - 16'd1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_time      <= '0;
            r_pend_act  <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a new result when free, else drop the one just taken.
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt      <= '0;
                    r_pend_act <= 1'b0;
                    r_found    <= 1'b0;
                    if (in_fire) begin
                        r_item  <= i_in.data;
                        r_state <= (i_in.data.operation == srtf_pkg::OP_TICK) ? S_SCAN
                                                                               : S_FIND;
                    end
                end
                S_FIND: begin
                    if (!r_valid[r_cnt]) begin
                        r_valid[r_cnt] <= 1'b1;
                        r_res   <= make_res(srtf_pkg::ST_ACCEPT, '0, 1'b0, '0, '0, '0);
                        r_state <= S_DONE;
                    end else if (r_cnt == LAST_IDX) begin
                        r_res   <= make_res(srtf_pkg::ST_FULL, '0, 1'b0, '0, '0, '0);
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SCAN, S_LAST: begin
                    // Fold in the slot read last cycle, issue the next read.
                    if (take) begin
                        r_found    <= 1'b1;
                        r_best     <= rd_entry;
                        r_best_idx <= r_pend_idx;
                    end
                    if (r_state == S_SCAN) begin
                        r_pend_act <= 1'b1;
                        r_pend_v   <= r_valid[r_cnt];
                        r_pend_idx <= r_cnt;
                        if (r_cnt == LAST_IDX) begin
                            r_state <= S_LAST;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end else begin
                        r_pend_act <= 1'b0;
                        r_state    <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_time <= r_time + 32'd1;
                    if (!r_found) begin
                        r_res   <= make_res(srtf_pkg::ST_IDLE, '0, 1'b0, '0, '0, '0);
                        r_state <= S_DONE;
                    end else if (r_best.rem <= 16'd1) begin
                        r_valid[r_best_idx] <= 1'b0;
                        r_ct    <= r_time + 32'd1;
                        r_state <= S_TAT;
                    end else begin
                        r_res   <= make_res(srtf_pkg::ST_SERVED, r_best.id, 1'b0, '0, '0, '0);
                        r_state <= S_DONE;
                    end
                end
                S_TAT: begin
                    r_tat   <= sub_y;
                    r_state <= S_WT;
                end
                S_WT: begin
                    r_res   <= make_res(srtf_pkg::ST_SERVED, r_best.id, 1'b1, r_ct, r_tat,
                                        sub_y);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Hold until the output register can take the result.
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SRTF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, !i_in.ready)
    `SRTF_ASSERT_NOW(a_finish_is_served, i_clk, i_rst_n, r_out_valid && r_out.finished,
                     r_out.status == srtf_pkg::ST_SERVED)
    `SRTF_ASSERT_NOW(a_idle_fields_zero, i_clk, i_rst_n,
                     r_out_valid && (r_out.status == srtf_pkg::ST_IDLE),
                     (r_out.served_id == 8'd0) && !r_out.finished)
    `SRTF_ASSERT_NOW(a_best_is_valid, i_clk, i_rst_n,
                     r_found && ((r_state == S_SCAN) || (r_state == S_LAST) ||
                                 (r_state == S_UPD)),
                     r_valid[r_best_idx])
    `SRTF_ASSERT_NEXT(a_finish_frees_slot, i_clk, i_rst_n,
                      (r_state == S_UPD) && r_found && (r_best.rem <= 16'd1),
                      !r_valid[r_best_idx])

endmodule

[sim/tb.sv]
// Self-checking testbench for the SRTF process scheduler.
module tb;
    import srtf_pkg::*;

    localparam int RANDOM_PER_PHASE = 342;
    localparam int QUIET_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 3 * SLOTS;
    localparam int PLAN_ROWS        = 25;

    typedef struct packed {
        t_op         op;
        logic [7:0]  id;
        logic [15:0] burst;
        logic        typed;
        t_status     st;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;

    srtf_in_if  in_ch ();
    srtf_out_if out_ch ();

    srtf_process_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Mirror of the process table
    logic        slot_busy  [SLOTS];
    logic [7:0]  slot_pid   [SLOTS];
    logic [15:0] slot_left  [SLOTS];
    logic [15:0] slot_burst [SLOTS];
    logic [31:0] slot_arr   [SLOTS];
    logic [31:0] now_time;

    t_out_word due_results [$];
    logic      typed_pending;
    t_out_word typed_word;

    int src_gap_pct;
    int sink_stall_pct;
    int err_count;
    int quiet_cycles;
    int finish_count;
    int status_count [4];

    string field_name [6] = '{"status", "served_id", "finished", "completion_time",
                              "turnaround", "waiting"};

    t_plan_row plan [PLAN_ROWS];

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Apply one word to the table mirror and return the result it should produce.
    function automatic t_out_word schedule_item(t_in_word w);
        t_out_word   r;
        int          pick;
        logic [31:0] tat;
        r    = '0;
        pick = -1;
        if (w.operation == OP_ARRIVE) begin
            r.status = ST_FULL;
            for (int k = 0; k < SLOTS; k++) begin
                if (!slot_busy[k] && pick < 0) pick = k;
            end
            if (pick >= 0) begin
                slot_busy[pick]  = 1'b1;
                slot_pid[pick]   = w.proc_id;
                slot_left[pick]  = w.burst;
                slot_burst[pick] = w.burst;
                slot_arr[pick]   = now_time;
                r.status         = ST_ACCEPT;
            end
        end else begin
            for (int k = 0; k < SLOTS; k++) begin
                if (slot_busy[k] && (pick < 0 || slot_left[k] < slot_left[pick] ||
                    (slot_left[k] == slot_left[pick] && slot_arr[k] < slot_arr[pick])))
                    pick = k;
            end
            now_time = now_time + 32'd1;
            if (pick < 0) begin
                r.status = ST_IDLE;
            end else begin
                r.status    = ST_SERVED;
                r.served_id = slot_pid[pick];
                // A zero burst finishes on its first tick without wrapping.
                if (slot_left[pick] <= 16'd1) begin
                    tat               = now_time - slot_arr[pick];
                    r.finished        = 1'b1;
                    r.completion_time = now_time;
                    r.turnaround      = tat;
                    r.waiting         = tat - {16'd0, slot_burst[pick]};
                    slot_left[pick]   = 16'd0;
                    slot_busy[pick]   = 1'b0;
                end else begin
                    slot_left[pick] = slot_left[pick] - 16'd1;
                end
            end
        end
        return r;
    endfunction

    task automatic send_word(input t_in_word w, input logic typed, input t_status st);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        typed_pending     = typed;
        typed_word        = '0;
        typed_word.status = st;
        in_ch.data  <= w;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_word   want;
        t_out_word   got;
        logic [31:0] wf [6];
        logic [31:0] gf [6];
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                want = schedule_item(in_ch.data);
                if (typed_pending) want = typed_word;
                due_results.push_back(want);
            end
            if (out_ch.valid === 1'b1 && out_ch.ready) begin
                got = out_ch.data;
                if (due_results.size() == 0) begin
                    err_count++;
                    $display("%0t: result %h arrived with nothing expected", $time, got);
                end else begin
                    want = due_results.pop_front();
                    wf = '{32'(want.status), 32'(want.served_id), 32'(want.finished),
                           want.completion_time, want.turnaround, want.waiting};
                    gf = '{32'(got.status), 32'(got.served_id), 32'(got.finished),
                           got.completion_time, got.turnaround, got.waiting};
                    for (int f = 0; f < 6; f++) begin
                        if (wf[f] !== gf[f]) begin
                            err_count++;
                            $display("%0t: %s expected %0h got %0h", $time, field_name[f],
                                     wf[f], gf[f]);
                        end
                    end
                end
                status_count[got.status]++;
                if (got.status == ST_SERVED && got.finished) finish_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid === 1'b1 && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, due_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_in_word w;
        int       p;
        int       busy;
        int       sel;
        logic     flood;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        out_ch.ready  = 1'b0;
        typed_pending = 1'b0;
        typed_word    = '0;
        err_count     = 0;
        quiet_cycles  = 0;
        finish_count  = 0;
        status_count  = '{default: 0};
        now_time      = '0;
        for (int k = 0; k < SLOTS; k++) begin
            slot_busy[k]  = 1'b0;
            slot_pid[k]   = '0;
            slot_left[k]  = '0;
            slot_burst[k] = '0;
            slot_arr[k]   = '0;
        end
        src_gap_pct    = 38;
        sink_stall_pct = 48;

        // Idle tick, fill all slots with extremes and a zero burst, overflow,
        // then tick through ties on remaining time and arrival.
        plan = '{
            '{OP_TICK,   8'h00, 16'h0000, 1'b1, ST_IDLE},
            '{OP_ARRIVE, 8'h00, 16'h0001, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'hFF, 16'hFFFF, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'h5A, 16'h0000, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'h11, 16'h0002, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'h22, 16'h0002, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'h33, 16'h0003, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'h44, 16'h0004, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'h55, 16'h0005, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'h66, 16'h0006, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'h77, 16'h0007, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'h88, 16'h0008, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'h99, 16'h0009, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'hAA, 16'h000A, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'hBB, 16'h000B, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'hCC, 16'h000C, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'hDD, 16'h000D, 1'b1, ST_ACCEPT},
            '{OP_ARRIVE, 8'hEE, 16'h0001, 1'b1, ST_FULL},
            '{OP_TICK,   8'hFF, 16'hFFFF, 1'b0, ST_SERVED},
            '{OP_TICK,   8'h00, 16'h0000, 1'b0, ST_SERVED},
            '{OP_ARRIVE, 8'hA5, 16'h0002, 1'b1, ST_ACCEPT},
            '{OP_TICK,   8'h00, 16'h0000, 1'b0, ST_SERVED},
            '{OP_TICK,   8'h00, 16'h0000, 1'b0, ST_SERVED},
            '{OP_TICK,   8'h00, 16'h0000, 1'b0, ST_SERVED},
            '{OP_TICK,   8'h00, 16'h0000, 1'b0, ST_SERVED}
        };

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++) begin
            w.operation = plan[r].op;
            w.proc_id   = plan[r].id;
            w.burst     = plan[r].burst;
            send_word(w, plan[r].typed, plan[r].st);
        end

        for (int ph = 0; ph < 3; ph++) begin
            src_gap_pct    = (ph == 0) ? 38 : (ph == 1) ? 48 : 0;
            sink_stall_pct = (ph == 0) ? 48 : (ph == 1) ? 38 : 0;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                busy = 0;
                for (int k = 0; k < SLOTS; k++) begin
                    if (slot_busy[k]) busy++;
                end
                // Flood arrivals now and then to hit the full table; otherwise
                // steer the arrival rate by how full the table is.
                flood = (i % 100) < 12;
                p = flood ? 90 : (busy < 4) ? 50 : (busy < 10) ? 20 : 8;
                w.operation = ($urandom_range(0, 99) < p) ? OP_ARRIVE : OP_TICK;
                w.proc_id   = 8'($urandom_range(0, 255));
                sel = $urandom_range(0, 99);
                if (sel < 8)
                    w.burst = 16'd0;
                else if (sel < 70)
                    w.burst = 16'($urandom_range(1, 4));
                else if (sel < 93)
                    w.burst = 16'($urandom_range(5, 12));
                else if (sel < 99)
                    w.burst = 16'($urandom_range(13, 60));
                else
                    w.burst = 16'($urandom_range(0, 65535));
                send_word(w, 1'b0, ST_ACCEPT);
            end
        end
        in_ch.valid <= 1'b0;

        while (due_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d words: %0d arrivals taken, %0d refused on a full table,",
                 PLAN_ROWS + 3 * RANDOM_PER_PHASE, status_count[ST_ACCEPT],
                 status_count[ST_FULL]);
        $display("%0d ticks served (%0d completions), %0d idle ticks, %0d mismatches.",
                 status_count[ST_SERVED], finish_count, status_count[ST_IDLE], err_count);
        if (err_count == 0 && due_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
